FILE: hw/rtl/flog_pkg.sv
// ----------------------------------------------------------------------------
// flog_pkg
// shared types and constants for the fast log10 approximation block
// ----------------------------------------------------------------------------
package flog_pkg;

  // input and output field widths
  localparam int SAMPLE_W = 32;
  localparam int LOG_W    = 20;
  localparam int EXP_W    = 7;

  // decoupling queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // horner coefficients, signed q.28
  localparam logic        [28:0] POLY_C0 = 29'd330577167;
  localparam logic signed [31:0] POLY_C1 = -32'sd1105558180;
  localparam logic signed [31:0] POLY_C2 = 32'sd1616510301;
  localparam logic signed [31:0] POLY_C3 = -32'sd841267190;

  // log10(2) in unsigned q.30
  localparam logic [28:0] LOG10_2_Q30 = 29'd323228497;

  // saturation limits of the result
  localparam logic [19:0] LOG_MAX = 20'h7FFFF;
  localparam logic [19:0] LOG_MIN = 20'h80000;

  // width of the scaled sum (y + e * 2^28)
  localparam int SUM_W = 36;

  // normalized sample handed from front to back
  typedef struct packed {
    logic [SAMPLE_W-1:0] frac;   // mantissa, q0.32, leading one at msb
    logic [EXP_W-1:0]    expo;   // signed binary exponent
    logic                zero;   // sample was zero
  } norm_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

FILE: hw/rtl/flog_front.sv
// ----------------------------------------------------------------------------
// flog_front
// accepts samples, takes magnitude and leading-one position, normalizes
// ----------------------------------------------------------------------------
module flog_front #(
  parameter int IN_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [flog_pkg::SAMPLE_W-1:0]       s_tdata,
  input  flog_pkg::qstat_t                    qstat,
  output logic                                push,
  output flog_pkg::norm_t                     push_data
);

  logic                          vld;
  logic [flog_pkg::SAMPLE_W-1:0] mag;
  logic [4:0]                    lead;
  logic                          zero;
  logic                          load;
  logic [flog_pkg::SAMPLE_W-1:0] mag_in;
  logic [4:0]                    lead_in;
  logic [4:0]                    shamt;

  assign load     = !vld || !qstat.full;
  // no request is taken while reset is held
  assign s_tready = load && !rst;

  // magnitude and priority encode
  always_comb begin
    mag_in  = s_tdata[31] ? (~s_tdata + 32'd1) : s_tdata;
    lead_in = 5'd0;
    for (int b = 0; b < flog_pkg::SAMPLE_W; b++) begin
      if (mag_in[b]) begin
        lead_in = 5'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (load) begin
      vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mag  <= mag_in;
      lead <= lead_in;
      zero <= (mag_in == '0);
    end
  end

  // normalize so the leading one sits at bit 31
  always_comb begin
    shamt          = 5'd31 - lead;
    push_data.frac = mag << shamt;
    push_data.zero = zero;
    if (zero) begin
      push_data.expo = '0;
    end else begin
      push_data.expo = 7'(lead) + 7'd1 - 7'(IN_FRAC_BITS);
    end
  end

  assign push = vld && !qstat.full;

endmodule

FILE: hw/rtl/flog_queue.sv
// ----------------------------------------------------------------------------
// flog_queue
// short fifo that decouples the normalizer from the polynomial pipeline
// ----------------------------------------------------------------------------
module flog_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  flog_pkg::norm_t  push_data,
  input  logic             pop,
  output flog_pkg::norm_t  head,
  output flog_pkg::qstat_t qstat
);

  flog_pkg::norm_t             mem [flog_pkg::QDEPTH];
  logic [flog_pkg::QPTR_W-1:0] wr_ptr;
  logic [flog_pkg::QPTR_W-1:0] rd_ptr;
  logic [flog_pkg::QCNT_W-1:0] count;

  assign qstat.full  = (count == flog_pkg::QCNT_W'(flog_pkg::QDEPTH));
  assign qstat.empty = (count == '0);
  assign head        = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hw/rtl/flog_back.sv
// ----------------------------------------------------------------------------
// flog_back
// horner cubic, exponent add, log10(2) scale, round and saturate
// ----------------------------------------------------------------------------
module flog_back #(
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  flog_pkg::norm_t              head,
  input  flog_pkg::qstat_t             qstat,
  output logic                         pop,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [flog_pkg::LOG_W-1:0]   log_value,
  output logic                         zero_input
);

  localparam int SH = 58 - OUT_FRAC_BITS;
  localparam int SW = flog_pkg::SUM_W;

  logic       en;
  logic [7:1] vld;

  // stage payloads
  logic [60:0]            p1;
  logic signed [31:0]     y1, y2;
  logic [62:0]            p3, p5;
  logic                   neg3, neg5, neg7;
  logic signed [SW-1:0]   sum6;
  logic [63:0]            p7;
  logic [31:0]            f1, f2, f3, f4;
  logic [6:0]             e1, e2, e3, e4, e5;
  logic                   z1, z2, z3, z4, z5, z6, z7;

  // combinational terms
  logic [63:0]            r1w, r3w, r5w;
  logic [31:0]            m2, m4;
  logic signed [31:0]     y3;
  logic [SW-1:0]          m6;
  logic [64:0]            rrw;
  logic [64:0]            rr;
  logic [flog_pkg::LOG_W-1:0] res;

  assign en  = !m_tvalid || m_tready;
  assign pop = en && !qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vld      <= {vld[6:1], pop};
      m_tvalid <= vld[7];
    end
  end

  // rounding and sign handling between multiplies
  always_comb begin
    r1w = {3'b000, p1} + 64'h8000_0000;
    m2  = y1[31] ? (~y1 + 32'sd1) : y1;
    r3w = {1'b0, p3} + 64'h8000_0000;
    m4  = y2[31] ? (~y2 + 32'sd1) : y2;
    r5w = {1'b0, p5} + 64'h8000_0000;
    y3  = (neg5 ? -$signed(r5w[63:32]) : $signed(r5w[63:32])) + flog_pkg::POLY_C3;
    m6  = sum6[SW-1] ? (~sum6 + 1'b1) : sum6;
    rrw = {1'b0, p7} + (65'd1 << (SH - 1));
    rr  = rrw >> SH;
    if (!neg7 && rr > 65'(flog_pkg::LOG_MAX)) begin
      res = flog_pkg::LOG_MAX;
    end else if (neg7 && rr > 65'(20'h80000)) begin
      res = flog_pkg::LOG_MIN;
    end else if (neg7) begin
      res = -rr[flog_pkg::LOG_W-1:0];
    end else begin
      res = rr[flog_pkg::LOG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // c0 * f
      p1   <= flog_pkg::POLY_C0 * head.frac;
      f1   <= head.frac;
      e1   <= head.expo;
      z1   <= head.zero;
      // + c1
      y1   <= $signed(r1w[63:32]) + flog_pkg::POLY_C1;
      f2   <= f1;
      e2   <= e1;
      z2   <= z1;
      // y1 * f
      neg3 <= y1[31];
      p3   <= m2[30:0] * f2;
      f3   <= f2;
      e3   <= e2;
      z3   <= z2;
      // + c2
      y2   <= (neg3 ? -$signed(r3w[63:32]) : $signed(r3w[63:32])) + flog_pkg::POLY_C2;
      f4   <= f3;
      e4   <= e3;
      z4   <= z3;
      // y2 * f
      neg5 <= y2[31];
      p5   <= m4[30:0] * f4;
      e5   <= e4;
      z5   <= z4;
      // + c3 + e * 2^28
      sum6 <= SW'(y3) + $signed({{(SW-35){e5[6]}}, e5, 28'd0});
      z6   <= z5;
      // scale by log10(2)
      neg7 <= sum6[SW-1];
      p7   <= m6[34:0] * flog_pkg::LOG10_2_Q30;
      z7   <= z6;
      // round, saturate, output register
      log_value  <= res;
      zero_input <= z7;
    end
  end

endmodule

FILE: hw/rtl/fast_log10_approx.sv
// ----------------------------------------------------------------------------
// fast_log10_approx
// streaming approximate log10 of the magnitude of a signed fixed-point sample
// ----------------------------------------------------------------------------
// usage:
//   s_* carries one sample per request (IN_FRAC_BITS fraction bits, only the
//   magnitude is used). m_* returns one result per request: log_value in
//   m_tdata with OUT_FRAC_BITS fraction bits, zero_input in m_tuser.
// throughput: one request per cycle while m_tready stays high: the front
//   normalizer, queue and eight-stage arithmetic pipeline all move each cycle.
// path: from input acceptance to m_tvalid a request passes, with no stall, one
//   normalizer register, one queue slot, seven arithmetic stages and the
//   output register; the four cubic/scale multiplies set the stage count.
// reset: rst is synchronous; it empties the queue and clears all valid
//   bits, so nothing is presented after reset. no stored state beyond that.
// stall: with m_tvalid high and m_tready low the arithmetic pipeline holds;
//   the front accepts until the 4-entry queue fills, then s_tready drops.
// a zero sample gives c3 * log10(2) (about -0.9434) with zero_input set;
// results beyond the 20-bit range saturate.
// ----------------------------------------------------------------------------
module fast_log10_approx #(
  parameter int IN_FRAC_BITS  = 16,
  parameter int OUT_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [19:0] log_value, [23:20] zero fill
  output logic [0:0]  m_tuser    // [0] zero_input
);

  localparam int SH          = 58 - OUT_FRAC_BITS;
  localparam int MAX_INFLIGHT = 1 + flog_pkg::QDEPTH + 8;

  // expected result for a zero sample, c3 * log10(2) rounded and saturated
  localparam longint unsigned ZERO_PROD = 64'd841267190 * 64'd323228497;
  localparam longint unsigned ZERO_MAG  = (ZERO_PROD + (64'd1 << (SH - 1))) >> SH;
  localparam logic [19:0]     ZERO_LOG  = (ZERO_MAG > 64'd524288) ? flog_pkg::LOG_MIN :
                                          -(20'(ZERO_MAG));

  flog_pkg::norm_t  push_data;
  flog_pkg::norm_t  head;
  flog_pkg::qstat_t qstat;
  logic             push;
  logic             pop;
  logic [19:0]      log_value;
  logic             zero_input;

  // sample normalizer
  flog_front #(
    .IN_FRAC_BITS (IN_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  // decoupling queue
  flog_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // polynomial and scale pipeline
  flog_back #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .qstat      (qstat),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .log_value  (log_value),
    .zero_input (zero_input)
  );

  assign m_tdata = {4'd0, log_value};
  assign m_tuser = zero_input;

  // requests inside the block, for checking only
  logic [3:0] inflight;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + 4'(s_tvalid && s_tready) - 4'(m_tvalid && m_tready);
    end
  end

  // never more requests held than storage slots
  a_inflight_bound : assert property (@(posedge clk) disable iff (rst)
    inflight <= 4'(MAX_INFLIGHT))
    else $error("more requests in flight than the block can hold");

  // a result is only presented for a request that was taken
  a_out_has_source : assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> inflight != 4'd0)
    else $error("result presented with no request in flight");

  // zero samples always map to the constant term result
  a_zero_result : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> m_tdata[19:0] == ZERO_LOG)
    else $error("zero sample gave unexpected log value");

endmodule

FILE: bench/tb_fast_log10_approx.sv
// ----------------------------------------------------------------------------
// tb_fast_log10_approx
// self-checking stream bench for the approximate log10 block
// ----------------------------------------------------------------------------
// every accepted sample is run through a bit-exact fixed-point model of the
// leading-one split, the cubic horner evaluation and the log10(2) scaling.
// the predicted result is queued, and each result leaving the block is
// compared with the oldest prediction. the run covers directed corner
// samples first. random samples follow, in phases that idle the sender,
// stall the receiver, do both, or do neither.
// ----------------------------------------------------------------------------
module tb_fast_log10_approx;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_FRAC    = 16;
  localparam int OUT_FRAC   = 16;
  localparam int RAND_ITEMS = 1500;
  localparam int TIMEOUT    = 200000;  // cycles, far beyond the slowest correct run
  localparam int TAIL       = 30;      // settle cycles after the last result
  localparam int SHOW_MAX   = 10;

  // horner coefficients in signed q.28 and log10(2) in unsigned q.30
  localparam longint HORNER_K0 = 330577167;
  localparam longint HORNER_K1 = -1105558180;
  localparam longint HORNER_K2 = 1616510301;
  localparam longint HORNER_K3 = -841267190;
  localparam longint unsigned LG2_Q30 = 323228497;
  localparam longint LOG_HI = 524287;
  localparam longint LOG_LO = -524288;

  typedef struct packed {
    logic [flog_pkg::LOG_W-1:0] log_value;
    logic                       zero_input;
  } log_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [flog_pkg::SAMPLE_W-1:0] s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [23:0]                   m_tdata;
  logic [0:0]                    m_tuser;

  logic [flog_pkg::SAMPLE_W-1:0] pending_samples[$];
  log_result_t                   expected_logs[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int requests_sent  = 0;
  int results_seen   = 0;
  int zero_requests  = 0;
  int cycles         = 0;

  fast_log10_approx #(
    .IN_FRAC_BITS  (IN_FRAC),
    .OUT_FRAC_BITS (OUT_FRAC)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  // (a * b) / 2^sh rounded to nearest, ties away from zero
  function automatic longint scaled_round(longint a, longint unsigned b, int sh);
    longint unsigned amag;
    longint unsigned prod;
    longint unsigned r;
    amag = (a < 0) ? -a : a;
    prod = amag * b;
    r = (prod + (64'd1 << (sh - 1))) >> sh;
    return (a < 0) ? -longint'(r) : longint'(r);
  endfunction

  // expected result of one sample
  function automatic log_result_t predict_log10(logic [flog_pkg::SAMPLE_W-1:0] smp);
    log_result_t     res;
    longint          sval;
    longint unsigned amag;
    longint unsigned mant;
    longint          expo;
    longint          acc;
    longint          lg;
    int              lead;
    sval = longint'($signed(smp));
    amag = (sval < 0) ? -sval : sval;
    mant = 0;
    expo = 0;
    lead = 0;
    if (amag != 0) begin
      for (int b = 0; b < 32; b++)
        if (amag[b])
          lead = b;
      // mantissa in q0.32 with the leading one at bit 31
      mant = amag << (31 - lead);
      expo = lead + 1 - IN_FRAC;
    end
    acc = HORNER_K0;
    acc = scaled_round(acc, mant, 32) + HORNER_K1;
    acc = scaled_round(acc, mant, 32) + HORNER_K2;
    acc = scaled_round(acc, mant, 32) + HORNER_K3;
    acc = acc + expo * (64'sd1 <<< 28);
    lg = scaled_round(acc, LG2_Q30, 58 - OUT_FRAC);
    if (lg > LOG_HI)
      lg = LOG_HI;
    if (lg < LOG_LO)
      lg = LOG_LO;
    res.log_value  = lg[flog_pkg::LOG_W-1:0];
    res.zero_input = (amag == 0);
    return res;
  endfunction

  // random sample: mostly varied magnitudes, some zeros and powers of two
  function automatic logic [flog_pkg::SAMPLE_W-1:0] random_sample();
    logic [flog_pkg::SAMPLE_W-1:0] v;
    int kind;
    kind = $urandom_range(9);
    case (kind)
      0: begin
        v = '0;
      end
      1: begin
        v = 32'd1 << $urandom_range(31);
        if ($urandom_range(1))
          v = -v;
      end
      2, 3, 4, 5: begin
        // spread the leading one over all positions
        v = $urandom() >> $urandom_range(31);
        if ($urandom_range(1))
          v = -v;
      end
      default: begin
        v = $urandom();
      end
    endcase
    return v;
  endfunction

  // sender: offers the next pending sample, predicts on acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_logs.push_back(predict_log10(s_tdata));
        requests_sent++;
        if (s_tdata == '0)
          zero_requests++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pending_samples.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random back-pressure, checks each result against the oldest prediction
  always @(posedge clk) begin
    log_result_t want;
    log_result_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        got.log_value  = m_tdata[flog_pkg::LOG_W-1:0];
        got.zero_input = m_tuser[0];
        if (expected_logs.size() == 0) begin
          if (mismatches < SHOW_MAX)
            $display("unexpected result log_value=%h zero_input=%b",
                     got.log_value, got.zero_input);
          mismatches++;
        end else begin
          want = expected_logs.pop_front();
          if (got.log_value != want.log_value || got.zero_input != want.zero_input) begin
            if (mismatches < SHOW_MAX)
              $display("result %0d: log_value exp %h got %h, zero_input exp %b got %b",
                       results_seen, want.log_value, got.log_value,
                       want.zero_input, got.zero_input);
            mismatches++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > TIMEOUT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_fast_log10_approx failed");
      $finish;
    end
  end

  // the run holds off here until every request has come back
  task automatic drain();
    do
      @(negedge clk);
    while (pending_samples.size() != 0 || s_tvalid || expected_logs.size() != 0);
  endtask

  task automatic random_phase(int n, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++)
      pending_samples.push_back(random_sample());
    drain();
  endtask

  initial begin
    logic [flog_pkg::SAMPLE_W-1:0] corner[$];
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // corners: zero, both extremes, most negative, unit values, bit patterns
    corner = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h8000_0001, 32'h0001_0000, 32'hFFFF_0000,
               32'h000A_0000, 32'h0000_8000, 32'h4000_0000, 32'h5555_5555,
               32'hAAAA_AAAA, 32'h0000_FFFF, 32'h0000_0002, 32'h0001_8000,
               32'hFFFF_FFFE, 32'h0064_0000, 32'h0001_999A, 32'hC000_0000,
               32'h0000_0000};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (corner[i])
      pending_samples.push_back(corner[i]);
    drain();

    random_phase(RAND_ITEMS / 4, 0, 0);
    random_phase(RAND_ITEMS / 4, 59, 0);
    random_phase(RAND_ITEMS / 4, 0, 59);
    random_phase(RAND_ITEMS / 4, 21, 21);

    repeat (TAIL) @(negedge clk);

    $display("%0d requests (%0d zero samples), %0d results checked, %0d mismatches",
             requests_sent, zero_requests, results_seen, mismatches);
    $display("corner samples, then random magnitudes under four idle and stall mixes");
    if (mismatches == 0 && expected_logs.size() == 0) begin
      $display("tb_fast_log10_approx passed");
    end else begin
      if (expected_logs.size() != 0)
        $display("%0d results never arrived", expected_logs.size());
      $display("tb_fast_log10_approx failed");
    end
    $finish;
  end

endmodule
